### rtl/core/base64_stream_codec_defines.svh
// Assertion macros used by the checker file.
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64SC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b64sc check failed");

// Next-cycle implication, checked outside reset.
`define B64SC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64sc check failed");

`endif

### rtl/core/b64sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_e;

  // One completed group
  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] bits;
    logic [1:0]  nbytes;  // bytes in group (encode) or bytes to emit (decode)
    logic        last;
  } job_t;

  // Front to queue
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  // Queue to back
  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  localparam int unsigned JobQDepth = 2;

  localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  // Character to sextet; anything outside the alphabet gives zero
  function automatic logic [5:0] b64_sextet(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - 8'd71;
    end else if (c >= CH_D0 && c <= CH_D9) begin
      v = c + 8'd4;
    end else if (c == CH_PLUS) begin
      v = 8'd62;
    end else if (c == CH_SLASH) begin
      v = 8'd63;
    end
    return v[5:0];
  endfunction

  // Sextet to character of the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, s};
    if (w < 8'd26) begin
      r = w + CH_UP_A;
    end else if (w < 8'd52) begin
      r = w + 8'd71;
    end else if (w < 8'd62) begin
      r = w - 8'd4;
    end else if (w == 8'd62) begin
      r = CH_PLUS;
    end else begin
      r = CH_SLASH;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/b64sc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sc_front import b64sc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       mode_we_i,
  input  wire logic       mode_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_in_i,
  input  wire logic       in_last_i,
  output job_push_t       push_o
);

  logic        mode_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;

  logic [23:0] enc_bits;
  logic [2:0]  enc_pos;
  logic [23:0] dec_bits;
  logic        is_pad;
  logic [1:0]  npads;

  // Gathering arithmetic for both directions
  always_comb begin
    enc_bits = bits_q | ({16'd0, data_in_i} << (5'd16 - {pos_q, 3'b000}));
    enc_pos  = {1'b0, pos_q} + 3'd1;
    dec_bits = {bits_q[17:0], b64_sextet(data_in_i)};
    is_pad   = (data_in_i == CH_PAD);
    npads    = {1'b0, pad_q[1]} + {1'b0, is_pad};
  end

  // Classify the item and build a job when a group closes
  always_comb begin
    bits_d = bits_q;
    pos_d  = pos_q;
    pad_d  = pad_q;
    push_o = '0;
    if (accept_i) begin
      if (!mode_q) begin
        if (enc_pos == 3'd3 || in_last_i) begin
          push_o.valid       = 1'b1;
          push_o.job.kind    = JOB_ENC;
          push_o.job.bits    = enc_bits;
          push_o.job.nbytes  = enc_pos[1:0];
          push_o.job.last    = in_last_i;
          bits_d = '0;
          pos_d  = '0;
          pad_d  = '0;
        end else begin
          bits_d = enc_bits;
          pos_d  = enc_pos[1:0];
        end
      end else if (in_last_i && pos_q != 2'd3) begin
        // short message: single error item
        push_o.valid    = 1'b1;
        push_o.job.kind = JOB_ERR;
        push_o.job.last = 1'b1;
        bits_d = '0;
        pos_d  = '0;
        pad_d  = '0;
      end else if (pos_q != 2'd3) begin
        bits_d = dec_bits;
        pos_d  = pos_q + 2'd1;
        if (pos_q == 2'd2) begin
          pad_d = {is_pad, 1'b0};
        end
      end else begin
        push_o.valid      = 1'b1;
        push_o.job.kind   = JOB_DEC;
        push_o.job.bits   = dec_bits;
        push_o.job.nbytes = in_last_i ? (2'd3 - npads) : 2'd3;
        push_o.job.last   = in_last_i;
        bits_d = '0;
        pos_d  = '0;
        pad_d  = '0;
      end
    end
    // mode write drops a partial group
    if (mode_we_i) begin
      bits_d = '0;
      pos_d  = '0;
      pad_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bits_q <= '0;
      pos_q  <= '0;
      pad_q  <= '0;
    end else begin
      if (mode_we_i) begin
        mode_q <= mode_i;
      end
      bits_q <= bits_d;
      pos_q  <= pos_d;
      pad_q  <= pad_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/b64sc_jobq.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sc_jobq import b64sc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_push_t push_i,
  input  wire logic pop_i,
  output logic      full_o,
  output job_head_t head_o
);

  localparam int unsigned PtrW = $clog2(JobQDepth);
  localparam int unsigned CntW = $clog2(JobQDepth + 1);

  job_t            mem_q [JobQDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(JobQDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(JobQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(JobQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

### rtl/core/b64sc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sc_back import b64sc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  job_head_t       head_i,
  output logic            job_done_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      out_value_o,
  output logic            out_last_o,
  output logic            error_o
);

  logic [1:0] k_q;
  logic       out_valid_q;
  logic [7:0] value_q, value_d;
  logic       last_q, last_d;
  logic       err_q;
  logic [1:0] end_k;
  logic       at_end;
  logic       fire;
  logic [5:0] sext;

  assign fire       = head_i.valid && (!out_valid_q || pop_i);
  assign at_end     = (k_q == end_k);
  assign job_done_o = fire && at_end;

  // Pick the result for the current index
  always_comb begin
    sext = head_i.job.bits[5'd18 - 5'(k_q) * 5'd6 +: 6];
    case (head_i.job.kind)
      JOB_ENC: begin
        end_k   = 2'd3;
        value_d = (k_q <= head_i.job.nbytes) ? b64_char(sext) : CH_PAD;
      end
      JOB_DEC: begin
        end_k   = head_i.job.nbytes - 2'd1;
        value_d = head_i.job.bits[5'd16 - {k_q, 3'b000} +: 8];
      end
      default: begin
        end_k   = 2'd0;
        value_d = 8'd0;
      end
    endcase
    last_d = head_i.job.last && at_end;
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      value_q <= value_d;
      last_q  <= last_d;
      err_q   <= (head_i.job.kind == JOB_ERR);
    end
  end

  // Result index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        k_q         <= at_end ? 2'd0 : k_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_value_o = value_q;
  assign out_last_o  = last_q;
  assign error_o     = err_q;

endmodule

`default_nettype wire

### rtl/core/base64_stream_codec.sv
// Path: the item closing a group writes a job into the job queue; the back end then
// loads each result into its result register, which drives the output. Throughput: one
// item per cycle in while full is low, one result per cycle out while pop is held; the
// back end's single result register sets the pace: encode input stalls on full, decode
// 1 char/cycle. A two-entry queue lets the front take items while the back drains a group.
// Reset (rst_ni low, async): mode returns to encode, partial group, queue and output clear.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec import b64sc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       mode_we_i,
  input  wire logic       mode_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_in_i,
  input  wire logic       in_last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_value_o,
  output logic            out_last_o,
  output logic            error_o
);

  job_push_t job_push;
  job_head_t job_head;
  logic      job_done;
  logic      accept;

  assign accept = push && !full;

  b64sc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_we_i (mode_we_i),
    .mode_i    (mode_i),
    .accept_i  (accept),
    .data_in_i (data_in_i),
    .in_last_i (in_last_i),
    .push_o    (job_push)
  );

  b64sc_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .pop_i  (job_done),
    .full_o (full),
    .head_o (job_head)
  );

  b64sc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (job_head),
    .job_done_o  (job_done),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o),
    .error_o     (error_o)
  );

endmodule

`default_nettype wire

### rtl/core/b64sc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_codec_defines.svh"

module b64sc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       mode_we_i,
  input wire logic       mode_i,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_value_o,
  input wire logic       out_last_o,
  input wire logic       error_o
);

  // Track the mode as seen on the config port
  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (mode_we_i) begin
      mode_q <= mode_i;
    end
  end

  // Error item closes the message and carries a zero value
  `B64SC_ASSERT_NOW(a_err_last, !empty && error_o, out_last_o)
  `B64SC_ASSERT_NOW(a_err_zero, !empty && error_o, out_value_o == 8'd0)
  // Encoding never reports a length error
  `B64SC_ASSERT_NOW(a_enc_no_err, !empty && !mode_q && !mode_we_i, !error_o)
  // A waiting item stays put until taken
  `B64SC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_value_o))

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (.*);

`default_nettype wire
